FILE: rtl/dcc_refresh_packet_scheduler_defines.svh
// assertion macros for the refresh scheduler
`ifndef DCC_REFRESH_PACKET_SCHEDULER_DEFINES_SVH
`define DCC_REFRESH_PACKET_SCHEDULER_DEFINES_SVH
// implication checked on every clock outside reset
`define DCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define DCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/dcc_pkg.sv
`default_nettype none
package dcc_pkg;
    localparam int SLOTS = 64;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] FUNC_SPEED = 2'd0;
    localparam logic [1:0] FUNC_FUNCTION = 2'd1;
    localparam logic [1:0] FUNC_NEXT = 2'd2;

    localparam logic [28:0] GRP_F0 = 29'h0000001F;
    localparam logic [28:0] GRP_F5 = 29'h000001E0;
    localparam logic [28:0] GRP_F9 = 29'h00001E00;
    localparam logic [28:0] GRP_F13 = 29'h001FE000;
    localparam logic [28:0] GRP_F21 = 29'h1FE00000;

    localparam logic [7:0] INSTR_SPEED = 8'h3F;
    localparam logic [7:0] INSTR_F21 = 8'hDF;
    localparam logic [7:0] INSTR_F13 = 8'hDE;
    localparam logic [7:0] INSTR_F9 = 8'hA0;
    localparam logic [7:0] INSTR_F5 = 8'hB0;
    localparam logic [7:0] INSTR_F0 = 8'h80;
    localparam logic [7:0] LONG_ADDR = 8'hC0;
    localparam logic [13:0] LONG_LIMIT = 14'd128;

    typedef enum logic [2:0] {
        PKT_SPEED, PKT_F0, PKT_F5, PKT_F9, PKT_F13, PKT_F21
    } pkt_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WRITE, ST_SCAN, ST_EMIT, ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic load_item;     // capture input beat
        logic do_write;      // read-modify-write of a set item
        logic scan_start;    // reset scan pointer
        logic scan_step;     // examine current slot
        logic emit;          // build packet and update slot
    } dp_cmd_t;

    typedef struct packed {
        logic       is_next;
        logic       is_set;
        logic       hit;       // current scan slot qualifies
        logic       pass2;     // in reminder pass
        logic       pass_done; // last slot of a pass examined
        logic       any_occ;   // some slot occupied seen
    } dp_status_t;
endpackage
`default_nettype wire

FILE: rtl/dcc_ctrl.sv
`default_nettype none
module dcc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire dcc_pkg::dp_status_t sts,
    output dcc_pkg::dp_cmd_t     cmd
);
    import dcc_pkg::*;
    `include "dcc_refresh_packet_scheduler_defines.svh"

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.is_next) state_next = ST_SCAN;
                else state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (sts.hit) state_next = ST_EMIT;
                else if (sts.pass_done && (sts.pass2 || !sts.any_occ)) state_next = ST_EMIT;
            end
            ST_EMIT: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_WRITE:
            begin
                cmd.do_write = sts.is_set;
                cmd.scan_start = 1'b1;
            end
            ST_SCAN: cmd.scan_step = 1'b1;
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            ST_OUT: out_valid = 1'b1;
            default: ;
        endcase
    end

    `DCC_ASSERT_IMP(a_ready_idle, in_ready, !out_valid, "ready while result pending")
    `DCC_ASSERT_NXT(a_accept_write, in_valid && in_ready, state_reg == ST_WRITE,
        "accepted beat not processed")
    `DCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule
`default_nettype wire

FILE: rtl/dcc_dp.sv
`default_nettype none
module dcc_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dcc_pkg::dp_cmd_t cmd,
    output dcc_pkg::dp_status_t  sts,
    input  wire logic [1:0]      func,
    input  wire logic [13:0]     address,
    input  wire logic [6:0]      speed_step,
    input  wire logic            forwards,
    input  wire logic [4:0]      function_number,
    input  wire logic            switch_on,
    output logic                 packet_valid,
    output logic [1:0]           packet_length,
    output logic [7:0]           byte0,
    output logic [7:0]           byte1,
    output logic [7:0]           byte2
);
    import dcc_pkg::*;

    // one row per slot: addr, spd tgt/sent, dir tgt/sent, funcs tgt/sent, phase
    typedef struct packed {
        logic [13:0] addr;
        logic [6:0]  spd_t;
        logic [6:0]  spd_s;
        logic        dir_t;
        logic        dir_s;
        logic [28:0] fn_t;
        logic [28:0] fn_s;
        logic [2:0]  phase;
    } row_t;

    // slot table in memory with a registered read port, valid bits clear on reset
    row_t               tbl_mem [SLOTS];
    logic [SLOTS-1:0]   vld_reg;
    row_t               rd_row_reg;
    logic               rd_vld_reg;

    logic [1:0]  func_reg;
    logic [13:0] addr_reg;
    logic [6:0]  spd_reg;
    logic        fwd_reg;
    logic [4:0]  fnum_reg;
    logic        on_reg;
    logic [SLOT_W-1:0] last_reg, ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic        pass2_reg, occ_reg, found_reg;
    row_t        cur_reg;
    logic [SLOT_W-1:0] hit_slot_reg;

    logic [SLOT_W-1:0] wslot, rd_addr, ptr_next, wr_addr;
    logic  wr_en;
    row_t  wrow, prow, erow, wr_row;
    logic  occ_now, chg_now;
    logic [6:0] sp_inc;
    logic [28:0] diff;
    pkt_kind_t kind;
    logic [7:0] b0, b1, b2;
    logic [1:0] len;

    assign wslot = addr_reg[SLOT_W-1:0];
    // read data lines up with the pointer value of the next cycle
    assign rd_addr = cmd.load_item ? address[SLOT_W-1:0] : ptr_next;
    assign prow = rd_vld_reg ? rd_row_reg : '0;
    assign occ_now = prow.addr != 14'd0;
    assign chg_now = (prow.spd_t != prow.spd_s) || (prow.dir_t != prow.dir_s)
        || (prow.fn_t != prow.fn_s);

    assign sts.is_next = func_reg == FUNC_NEXT;
    assign sts.is_set = func_reg == FUNC_SPEED || func_reg == FUNC_FUNCTION;
    assign sts.hit = cmd.scan_step && occ_now && (pass2_reg || chg_now);
    assign sts.pass2 = pass2_reg;
    assign sts.pass_done = cnt_reg == CNT_W'(SLOTS - 1);
    assign sts.any_occ = occ_reg || occ_now;

    assign wr_en = cmd.do_write || (cmd.emit && found_reg);
    assign wr_addr = cmd.do_write ? wslot : hit_slot_reg;
    assign wr_row = cmd.do_write ? wrow : erow;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_start)
            ptr_next = last_reg + SLOT_W'(1);
        else if (cmd.scan_step && !sts.hit)
            ptr_next = ptr_reg + SLOT_W'(1);
    end

    // the row of the written slot was read at the capture edge
    always_comb
    begin
        sp_inc = (spd_reg != 7'd0 && spd_reg != 7'd127) ? spd_reg + 7'd1 : spd_reg;
        wrow = prow;
        wrow.addr = addr_reg;
        if (func_reg == FUNC_SPEED)
        begin
            wrow.spd_t = sp_inc;
            wrow.dir_t = fwd_reg;
        end
        else if (fnum_reg <= 5'd28)
        begin
            wrow.fn_t[fnum_reg] = on_reg;
        end
    end

    // packet construction on the captured row
    always_comb
    begin
        diff = cur_reg.fn_t ^ cur_reg.fn_s;
        if (!pass2_reg)
        begin
            if (cur_reg.spd_t != cur_reg.spd_s || cur_reg.dir_t != cur_reg.dir_s)
                kind = PKT_SPEED;
            else if ((diff & GRP_F0) != '0) kind = PKT_F0;
            else if ((diff & GRP_F5) != '0) kind = PKT_F5;
            else if ((diff & GRP_F9) != '0) kind = PKT_F9;
            else if ((diff & GRP_F13) != '0) kind = PKT_F13;
            else kind = PKT_F21;
        end
        else
        begin
            case (cur_reg.phase)
                3'd1: kind = PKT_F0;
                3'd2: kind = PKT_F5;
                3'd4: kind = PKT_F9;
                3'd5: kind = PKT_F13;
                3'd7: kind = PKT_F21;
                default: kind = PKT_SPEED;
            endcase
        end
        erow = cur_reg;
        if (pass2_reg) erow.phase = cur_reg.phase + 3'd1;
        b0 = cur_reg.addr[7:0];
        b1 = 8'd0;
        b2 = 8'd0;
        len = 2'd2;
        case (kind)
            PKT_SPEED:
            begin
                b1 = INSTR_SPEED;
                b2 = {cur_reg.dir_t, cur_reg.spd_t};
                len = 2'd3;
                erow.spd_s = cur_reg.spd_t;
                erow.dir_s = cur_reg.dir_t;
            end
            PKT_F0:
            begin
                if (cur_reg.addr < LONG_LIMIT)
                    b1 = INSTR_F0 | {3'd0, cur_reg.fn_t[0], cur_reg.fn_t[4:1]};
                else
                begin
                    b0 = LONG_ADDR | {2'd0, cur_reg.addr[13:8]};
                    b1 = cur_reg.addr[7:0];
                    b2 = INSTR_F0 | {3'd0, cur_reg.fn_t[0], cur_reg.fn_t[4:1]};
                    len = 2'd3;
                end
                erow.fn_s = (cur_reg.fn_s & ~GRP_F0) | (cur_reg.fn_t & GRP_F0);
            end
            PKT_F5:
            begin
                b1 = INSTR_F5 | {4'd0, cur_reg.fn_t[8:5]};
                erow.fn_s = (cur_reg.fn_s & ~GRP_F5) | (cur_reg.fn_t & GRP_F5);
            end
            PKT_F9:
            begin
                b1 = INSTR_F9 | {4'd0, cur_reg.fn_t[12:9]};
                erow.fn_s = (cur_reg.fn_s & ~GRP_F9) | (cur_reg.fn_t & GRP_F9);
            end
            PKT_F13:
            begin
                b1 = INSTR_F13;
                b2 = cur_reg.fn_t[20:13];
                len = 2'd3;
                erow.fn_s = (cur_reg.fn_s & ~GRP_F13) | (cur_reg.fn_t & GRP_F13);
            end
            default:
            begin
                b1 = INSTR_F21;
                b2 = cur_reg.fn_t[28:21];
                len = 2'd3;
                erow.fn_s = (cur_reg.fn_s & ~GRP_F21) | (cur_reg.fn_t & GRP_F21);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rd_vld_reg <= 1'b0;
            last_reg <= '0;
            ptr_reg <= '0;
            cnt_reg <= '0;
            pass2_reg <= 1'b0;
            occ_reg <= 1'b0;
            found_reg <= 1'b0;
            func_reg <= FUNC_SPEED;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            ptr_reg <= ptr_next;
            if (cmd.load_item) func_reg <= func;
            if (cmd.do_write) vld_reg[wslot] <= 1'b1;
            if (cmd.scan_start)
            begin
                cnt_reg <= '0;
                pass2_reg <= 1'b0;
                occ_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                occ_reg <= occ_reg || occ_now;
                if (sts.hit)
                begin
                    found_reg <= 1'b1;
                end
                else if (sts.pass_done)
                begin
                    cnt_reg <= '0;
                    pass2_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.emit && found_reg)
            begin
                last_reg <= hit_slot_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            addr_reg <= address;
            spd_reg <= speed_step;
            fwd_reg <= forwards;
            fnum_reg <= function_number;
            on_reg <= switch_on;
        end
        if (wr_en) tbl_mem[wr_addr] <= wr_row;
        rd_row_reg <= tbl_mem[rd_addr];
        if (sts.hit)
        begin
            cur_reg <= prow;
            hit_slot_reg <= ptr_reg;
        end
        if (cmd.emit)
        begin
            if (found_reg)
            begin
                packet_valid <= 1'b1;
                packet_length <= len;
                byte0 <= b0;
                byte1 <= b1;
                byte2 <= (len == 2'd3) ? b2 : 8'd0;
            end
            else
            begin
                packet_valid <= 1'b0;
                packet_length <= 2'd0;
                byte0 <= 8'd0;
                byte1 <= 8'd0;
                byte2 <= 8'd0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dcc_refresh_packet_scheduler.sv
// channel | valid    | ready     | payload
// in      | in_valid | in_ready  | func, address, speed_step, forwards, function_number, switch_on
// out     | out_valid| out_ready | packet_valid, packet_length, byte0, byte1, byte2
// a set item runs through capture, then table read-modify-write
// a next-packet item runs through capture, scan and emit: the scan visits one slot per
// cycle, a change pass then a reminder pass
// one item at a time; a result holds until out_ready, then the next beat is taken
// rst_n clears control and the slot valid bits, all slots read empty
`default_nettype none
module dcc_refresh_packet_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [13:0] address,
    input  wire logic [6:0]  speed_step,
    input  wire logic        forwards,
    input  wire logic [4:0]  function_number,
    input  wire logic        switch_on,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             packet_valid,
    output logic [1:0]       packet_length,
    output logic [7:0]       byte0,
    output logic [7:0]       byte1,
    output logic [7:0]       byte2
);
    import dcc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    // sequencer: accept, write or scan, emit, hold result beat
    dcc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
    );

    // slot table, scan pointer and packet builder
    dcc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .func(func),
        .address(address), .speed_step(speed_step), .forwards(forwards),
        .function_number(function_number), .switch_on(switch_on),
        .packet_valid(packet_valid), .packet_length(packet_length),
        .byte0(byte0), .byte1(byte1), .byte2(byte2)
    );
endmodule
`default_nettype wire

FILE: tb/dcc_refresh_packet_scheduler_test.sv
`default_nettype none
module dcc_refresh_packet_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dcc_pkg::*;

    // the selector code that the block leaves unused
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // cycles with no beat on either channel before the run is given up
    localparam int STALL_LIMIT = 20000;
    // extra wait after the expected packets are drained
    localparam int DRAIN_CYCLES = 4 * SLOTS + 20;

    typedef struct packed {
        logic       valid;
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } packet_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [13:0] address;
    logic [6:0]  speed_step;
    logic        forwards;
    logic [4:0]  function_number;
    logic        switch_on;
    logic        out_valid;
    logic        out_ready;
    logic        packet_valid;
    logic [1:0]  packet_length;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;

    dcc_refresh_packet_scheduler dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .address         (address),
        .speed_step      (speed_step),
        .forwards        (forwards),
        .function_number (function_number),
        .switch_on       (switch_on),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .packet_valid    (packet_valid),
        .packet_length   (packet_length),
        .byte0           (byte0),
        .byte1           (byte1),
        .byte2           (byte2)
    );

    // shadow copy of the decoder table
    logic [13:0] tbl_addr   [SLOTS];
    logic [6:0]  tbl_speed  [SLOTS];
    logic [6:0]  sent_speed [SLOTS];
    logic        tbl_dir    [SLOTS];
    logic        sent_dir   [SLOTS];
    logic [28:0] tbl_funcs  [SLOTS];
    logic [28:0] sent_funcs [SLOTS];
    logic [2:0]  remind_ph  [SLOTS];
    int          last_slot;

    packet_t     pending_packets[$];
    int          errors;
    int          beats_in;
    int          packets_out;
    int          empty_out;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // packet builders, each marks its group as sent
    // ---------------------------------------------------------------
    function automatic packet_t speed_packet(int s);
        packet_t p;
        p.valid = 1'b1;
        p.len = 2'd3;
        p.b0 = tbl_addr[s][7:0];
        p.b1 = INSTR_SPEED;
        p.b2 = {tbl_dir[s], tbl_speed[s]};
        sent_speed[s] = tbl_speed[s];
        sent_dir[s] = tbl_dir[s];
        return p;
    endfunction

    function automatic packet_t group_packet(int s, pkt_kind_t kind);
        packet_t p;
        logic [28:0] t;
        logic [28:0] m;
        t = tbl_funcs[s];
        p.valid = 1'b1;
        p.len = 2'd2;
        p.b0 = tbl_addr[s][7:0];
        p.b2 = 8'd0;
        case (kind)
            PKT_F0:
            begin
                m = GRP_F0;
                if (tbl_addr[s] < LONG_LIMIT)
                    p.b1 = INSTR_F0 | {3'b000, t[0], t[4:1]};
                else
                begin
                    // long address form, f0-4 goes in the third byte
                    p.b0 = LONG_ADDR | {2'b00, tbl_addr[s][13:8]};
                    p.b1 = tbl_addr[s][7:0];
                    p.b2 = INSTR_F0 | {3'b000, t[0], t[4:1]};
                    p.len = 2'd3;
                end
            end
            PKT_F5:
            begin
                m = GRP_F5;
                p.b1 = INSTR_F5 | {4'b0000, t[8:5]};
            end
            PKT_F9:
            begin
                m = GRP_F9;
                p.b1 = INSTR_F9 | {4'b0000, t[12:9]};
            end
            PKT_F13:
            begin
                m = GRP_F13;
                p.b1 = INSTR_F13;
                p.b2 = t[20:13];
                p.len = 2'd3;
            end
            default:
            begin
                m = GRP_F21;
                p.b1 = INSTR_F21;
                p.b2 = t[28:21];
                p.len = 2'd3;
            end
        endcase
        sent_funcs[s] = (sent_funcs[s] & ~m) | (t & m);
        return p;
    endfunction

    // ---------------------------------------------------------------
    // table update for one accepted beat, queues the packet it causes
    // ---------------------------------------------------------------
    task automatic apply_beat(logic [1:0] f, logic [13:0] a, logic [6:0] sp, logic dir,
                              logic [4:0] fn, logic on);
        int s;
        int k;
        int g;
        logic [6:0] stored;
        logic [28:0] diff;
        packet_t p;
        bit found;
        pkt_kind_t kinds[5];
        logic [28:0] masks[5];
        kinds = '{PKT_F0, PKT_F5, PKT_F9, PKT_F13, PKT_F21};
        masks = '{GRP_F0, GRP_F5, GRP_F9, GRP_F13, GRP_F21};
        s = a % SLOTS;
        found = 1'b0;
        p = '0;
        case (f)
            FUNC_SPEED:
            begin
                // nonzero steps are stored one up, 127 saturates
                stored = (sp != 0 && sp != 7'd127) ? sp + 7'd1 : sp;
                tbl_addr[s] = a;
                tbl_speed[s] = stored;
                tbl_dir[s] = dir;
            end
            FUNC_FUNCTION:
            begin
                tbl_addr[s] = a;
                if (fn <= 28)
                    tbl_funcs[s][fn] = on;
            end
            FUNC_NEXT:
            begin
                // first pass: first slot with a pending change after the last served slot
                for (k = 0; k < SLOTS && !found; k++)
                begin
                    s = (last_slot + 1 + k) % SLOTS;
                    if (tbl_addr[s] == 0)
                        continue;
                    if (tbl_speed[s] != sent_speed[s] || tbl_dir[s] != sent_dir[s])
                    begin
                        p = speed_packet(s);
                        found = 1'b1;
                    end
                    else
                    begin
                        diff = tbl_funcs[s] ^ sent_funcs[s];
                        for (g = 0; g < 5 && !found; g++)
                            if ((diff & masks[g]) != 0)
                            begin
                                p = group_packet(s, kinds[g]);
                                found = 1'b1;
                            end
                    end
                    if (found)
                        last_slot = s;
                end
                // second pass: reminder cycle of the next occupied slot
                for (k = 0; k < SLOTS && !found; k++)
                begin
                    s = (last_slot + 1 + k) % SLOTS;
                    if (tbl_addr[s] == 0)
                        continue;
                    case (remind_ph[s])
                        3'd1: p = group_packet(s, PKT_F0);
                        3'd2: p = group_packet(s, PKT_F5);
                        3'd4: p = group_packet(s, PKT_F9);
                        3'd5: p = group_packet(s, PKT_F13);
                        3'd7: p = group_packet(s, PKT_F21);
                        default: p = speed_packet(s);
                    endcase
                    remind_ph[s] = remind_ph[s] + 3'd1;
                    last_slot = s;
                    found = 1'b1;
                end
                pending_packets.push_back(p);
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // sender: one beat, idles at random first, holds valid until taken
    // ---------------------------------------------------------------
    task automatic send_beat(logic [1:0] f, logic [13:0] a, logic [6:0] sp = '0,
                             logic dir = 1'b0, logic [4:0] fn = '0, logic on = 1'b0);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            func <= 2'($urandom);
            address <= 14'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        address <= a;
        speed_step <= sp;
        forwards <= dir;
        function_number <= fn;
        switch_on <= on;
        do @(posedge clk); while (!(in_valid && in_ready));
        beats_in++;
        apply_beat(f, a, sp, dir, fn, on);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // receiver stalls at random
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_packets.size() == 0)
            begin
                errors++;
                $display("unexpected packet at %0t", $realtime);
            end
            else
            begin
                packet_t w;
                w = pending_packets.pop_front();
                if (packet_valid !== w.valid) report("packet_valid", 8'(packet_valid), 8'(w.valid));
                if (packet_length !== w.len) report("packet_length", 8'(packet_length), 8'(w.len));
                if (byte0 !== w.b0) report("byte0", byte0, w.b0);
                if (byte1 !== w.b1) report("byte1", byte1, w.b1);
                if (byte2 !== w.b2) report("byte2", byte2, w.b2);
                if (w.valid) packets_out++;
                else empty_out++;
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no progress for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        int k;
        // empty table gives an empty result
        send_beat(FUNC_NEXT, 14'd0);
        // address zero writes slot 0 but leaves it empty
        send_beat(FUNC_SPEED, 14'd0, 7'd50, 1'b1);
        send_beat(FUNC_NEXT, 14'd0);
        send_beat(FUNC_SPEED, 14'd3, 7'd126, 1'b1);
        send_beat(FUNC_SPEED, 14'd16383, 7'd127, 1'b0);
        send_beat(FUNC_SPEED, 14'd200, 7'd0, 1'b1);
        send_beat(FUNC_FUNCTION, 14'd3, 7'd0, 1'b0, 5'd0, 1'b1);
        send_beat(FUNC_FUNCTION, 14'd3, 7'd0, 1'b0, 5'd28, 1'b1);
        send_beat(FUNC_FUNCTION, 14'd200, 7'd0, 1'b0, 5'd1, 1'b1);
        send_beat(FUNC_FUNCTION, 14'd5, 7'd0, 1'b0, 5'd29, 1'b1);
        send_beat(FUNC_FUNCTION, 14'd6, 7'd0, 1'b0, 5'd31, 1'b0);
        send_beat(FUNC_UNUSED, 14'h3FFF, 7'h7F, 1'b1, 5'h1F, 1'b1);
        // slot sharing: 67 lands in the slot of 3
        send_beat(FUNC_FUNCTION, 14'd67, 7'd0, 1'b0, 5'd13, 1'b1);
        send_beat(FUNC_FUNCTION, 14'd3, 7'd0, 1'b0, 5'd28, 1'b0);
        // drain changes and run through the reminder cycle
        for (k = 0; k < 11; k++)
            send_beat(FUNC_NEXT, 14'($urandom));
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        int n;
        int r;
        logic [13:0] pool[8];
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        // a few decoders share slots, some use long addresses
        for (n = 0; n < 8; n++)
            pool[n] = (n < 4) ? 14'($urandom_range(127)) : 14'($urandom);
        pool[1] = pool[0] + 14'(SLOTS);
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 30)
                send_beat(FUNC_SPEED, (r < 3) ? 14'($urandom) : pool[$urandom_range(7)],
                          (r < 5) ? 7'd127 : 7'($urandom_range(126)), 1'($urandom));
            else if (r < 62)
                send_beat(FUNC_FUNCTION, (r < 33) ? 14'd0 : pool[$urandom_range(7)],
                          7'($urandom), 1'($urandom),
                          (r < 35) ? 5'($urandom) : 5'($urandom_range(28)), 1'($urandom));
            else if (r < 64)
                send_beat(FUNC_UNUSED, 14'($urandom), 7'($urandom), 1'($urandom),
                          5'($urandom), 1'($urandom));
            else
                send_beat(FUNC_NEXT, 14'($urandom));
        end
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        func = FUNC_SPEED;
        address = '0;
        speed_step = '0;
        forwards = 1'b0;
        function_number = '0;
        switch_on = 1'b0;
        errors = 0;
        beats_in = 0;
        packets_out = 0;
        empty_out = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        last_slot = 0;
        for (k = 0; k < SLOTS; k++)
        begin
            tbl_addr[k] = '0;
            tbl_speed[k] = '0;
            sent_speed[k] = '0;
            tbl_dir[k] = 1'b0;
            sent_dir[k] = 1'b0;
            tbl_funcs[k] = '0;
            sent_funcs[k] = '0;
            remind_ph[k] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(350, 0, 0);
        test_random(350, 82, 0);
        test_random(350, 0, 82);
        test_random(350, 21, 21);
        drop_valid();

        k = 0;
        while (pending_packets.size() != 0 && k < STALL_LIMIT)
        begin
            @(posedge clk);
            k++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d beats sent, %0d packets and %0d empty results checked",
                 beats_in, packets_out, empty_out);
        $display("idle phases: none, sender, receiver, both");
        if (errors == 0 && pending_packets.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d packets never seen", errors, pending_packets.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
